@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the vertex transform block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define VTPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vtpd assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define VTPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vtpd assertion failed");

`endif

@@ sv/vtpd_pkg.sv @@
// ---------------------------------------------------------------------------
// vtpd_pkg
// Widths, stage counts, status codes and shared types of the vertex transform.
// ---------------------------------------------------------------------------
package vtpd_pkg;

  localparam int COORD_W = 32;
  localparam int CFG_W   = 64;
  localparam int NUM_REG = 8;
  localparam int IDX_W   = 3;
  // Three products plus a translation term need two bits of headroom.
  localparam int SUM_W   = 2 * COORD_W + 2;
  // Quotient bits kept before saturation; larger quotients are flagged.
  localparam int Q_W     = COORD_W + 1;
  localparam int RW      = SUM_W + Q_W;
  localparam int MAC_ST  = 3;
  localparam int DIV_ST  = Q_W + 2;
  localparam int NST     = MAC_ST + DIV_ST + 1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_WZERO = 2'd2;

  typedef struct packed {
    logic           big;
    logic           neg;
    logic           zero;
    logic [Q_W-1:0] q;
  } lane_res_t;

endpackage

@@ sv/vtpd_mac.sv @@
// ---------------------------------------------------------------------------
// vtpd_mac
// Input register, product stage and row sum stage of the 4x4 transform.
// ---------------------------------------------------------------------------
module vtpd_mac import vtpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic [MAC_ST-1:0]              en,
  input  logic signed [COORD_W-1:0]      point_x,
  input  logic signed [COORD_W-1:0]      point_y,
  input  logic signed [COORD_W-1:0]      point_z,
  input  logic [NUM_REG-1:0][CFG_W-1:0]  mat,
  output logic signed [SUM_W-1:0]        sum [4]
);

  logic signed [COORD_W-1:0]   p_r [3];
  logic signed [2*COORD_W-1:0] prod_r [4][3];
  logic signed [SUM_W-1:0]     tr_r [4];
  logic signed [SUM_W-1:0]     sum_r [4];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r[0] <= point_x;
      p_r[1] <= point_y;
      p_r[2] <= point_z;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [COORD_W-1:0] e [4];
    for (genvar c = 0; c < 4; c++) begin : g_col
      if (r % 2 == 0) begin : g_lo
        assign e[c] = $signed(mat[2 * c + r / 2][COORD_W-1:0]);
      end else begin : g_hi
        assign e[c] = $signed(mat[2 * c + r / 2][CFG_W-1:COORD_W]);
      end
    end

    always_ff @(posedge clk) begin
      if (en[1]) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= e[c] * p_r[c];
        end
        tr_r[r] <= SUM_W'(e[3]) <<< FRAC_BITS;
      end
      if (en[2]) begin
        sum_r[r] <= SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1])
                  + SUM_W'(prod_r[r][2]) + tr_r[r];
      end
    end

    assign sum[r] = sum_r[r];
  end

endmodule

@@ sv/vtpd_div.sv @@
// ---------------------------------------------------------------------------
// vtpd_div
// Pipelined restoring divider: one quotient bit per stage, unsigned core.
// ---------------------------------------------------------------------------
module vtpd_div import vtpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic [DIV_ST-1:0]       en,
  input  logic signed [SUM_W-1:0] num,
  input  logic signed [SUM_W-1:0] den,
  output lane_res_t               res
);

  logic [SUM_W-1:0] num_mag;
  logic [SUM_W-1:0] den_mag;

  logic [RW-1:0]    n_pre_r;
  logic [SUM_W-1:0] d_pre_r;
  logic             neg_pre_r;
  logic             zero_pre_r;

  logic [RW-1:0]    rem_r  [Q_W+1];
  logic [SUM_W-1:0] d_r    [Q_W+1];
  logic [Q_W-1:0]   q_r    [Q_W+1];
  logic             big_r  [Q_W+1];
  logic             neg_r  [Q_W+1];
  logic             zero_r [Q_W+1];

  assign num_mag = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
  assign den_mag = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n_pre_r    <= RW'(num_mag) << FRAC_BITS;
      d_pre_r    <= den_mag;
      neg_pre_r  <= num[SUM_W-1] ^ den[SUM_W-1];
      zero_pre_r <= (den == '0);
    end
    // A quotient of 2^Q_W or more is only ever saturated, so flag it early.
    if (en[1]) begin
      rem_r[0]  <= n_pre_r;
      d_r[0]    <= d_pre_r;
      q_r[0]    <= '0;
      big_r[0]  <= (n_pre_r >= (RW'(d_pre_r) << Q_W));
      neg_r[0]  <= neg_pre_r;
      zero_r[0] <= zero_pre_r;
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    localparam int J = Q_W - 1 - s;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = RW'(d_r[s]) << J;
    assign take  = (rem_r[s] >= trial);

    always_ff @(posedge clk) begin
      if (en[s + 2]) begin
        rem_r[s+1]  <= take ? rem_r[s] - trial : rem_r[s];
        q_r[s+1]    <= q_r[s] | (Q_W'(take) << J);
        d_r[s+1]    <= d_r[s];
        big_r[s+1]  <= big_r[s];
        neg_r[s+1]  <= neg_r[s];
        zero_r[s+1] <= zero_r[s];
      end
    end
  end

  assign res.big  = big_r[Q_W];
  assign res.neg  = neg_r[Q_W];
  assign res.zero = zero_r[Q_W];
  assign res.q    = q_r[Q_W];

endmodule

@@ sv/vertex_transform_perspective_divide_top.sv @@
// ---------------------------------------------------------------------------
// vertex_transform_perspective_divide_top
// Q16.16 point times a 4x4 matrix, then division of x, y and z by w.
// ---------------------------------------------------------------------------
// Input items carry one point (in_point_x/y/z) and are taken at an edge where
// in_valid is high and in_stall is low. Each result item carries the projected
// point and a status code: ok, some coordinate saturated, or w was zero (then
// all coordinates are zero). The matrix is written through the cfg_ channel,
// one 64-bit register per write, two signed elements each; cfg_ready is always
// high and writes should only be made while no item is in flight.
// An item passes 39 register stages from the accepting edge to out_valid:
// three for the input register, the products and the row sums, two
// preparation stages, one stage per quotient bit of the restoring dividers
// (33 bits), and the saturating output register. Throughput is one item per
// cycle while in_stall is low.
// Each stage advances whenever it or any stage after it holds a bubble, so a
// stalled output keeps accepting items until the pipeline is full; only then
// is in_stall raised. Nothing is dropped or repeated during a stall.
// Reset loads the identity matrix and empties the pipeline.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_transform_perspective_divide_top import vtpd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_proj_x,
  output logic signed [COORD_W-1:0] out_proj_y,
  output logic signed [COORD_W-1:0] out_proj_z,
  output logic [1:0]                out_status,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;
  localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  // Identity matrix: diagonal elements in registers 0, 2, 5 and 7.
  localparam logic [NUM_REG-1:0][CFG_W-1:0] MAT_RESET = {
    {ONE, {COORD_W{1'b0}}}, {CFG_W{1'b0}},
    {{COORD_W{1'b0}}, ONE}, {CFG_W{1'b0}},
    {CFG_W{1'b0}},          {ONE, {COORD_W{1'b0}}},
    {CFG_W{1'b0}},          {{COORD_W{1'b0}}, ONE}
  };

  logic [NUM_REG-1:0][CFG_W-1:0] mat_r;
  logic [NST-1:0]                v_r;
  logic [NST-1:0]                rdy;
  logic signed [SUM_W-1:0]       sum [4];
  lane_res_t                     lane [3];
  logic [COORD_W-1:0]            proj_nxt [3];
  logic [2:0]                    sat;
  logic [1:0]                    status_nxt;
  logic [COORD_W-1:0]            proj_r [3];
  logic [1:0]                    status_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= MAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mat_r[cfg_index] <= cfg_data;
    end
  end

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_stall = !rdy[0];

  vtpd_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk     (clk),
    .en      (rdy[MAC_ST-1:0]),
    .point_x (in_point_x),
    .point_y (in_point_y),
    .point_z (in_point_z),
    .mat     (mat_r),
    .sum     (sum)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vtpd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (rdy[MAC_ST+DIV_ST-1:MAC_ST]),
      .num (sum[i]),
      .den (sum[3]),
      .res (lane[i])
    );

    always_comb begin
      sat[i]      = 1'b0;
      proj_nxt[i] = '0;
      if (lane[i].zero) begin
        proj_nxt[i] = '0;
      end else if (!lane[i].neg) begin
        if (lane[i].big || lane[i].q > Q_W'(POS_MAX)) begin
          sat[i]      = 1'b1;
          proj_nxt[i] = POS_MAX;
        end else begin
          proj_nxt[i] = lane[i].q[COORD_W-1:0];
        end
      end else begin
        if (lane[i].big || lane[i].q > Q_W'(NEG_MIN)) begin
          sat[i]      = 1'b1;
          proj_nxt[i] = NEG_MIN;
        end else begin
          proj_nxt[i] = COORD_W'(-lane[i].q);
        end
      end
    end
  end

  always_comb begin
    if (lane[0].zero) begin
      status_nxt = ST_WZERO;
    end else if (sat != 3'b000) begin
      status_nxt = ST_SAT;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      for (int i = 0; i < 3; i++) begin
        proj_r[i] <= proj_nxt[i];
      end
      status_r <= status_nxt;
    end
  end

  assign out_valid  = v_r[NST-1];
  assign out_proj_x = proj_r[0];
  assign out_proj_y = proj_r[1];
  assign out_proj_z = proj_r[2];
  assign out_status = status_r;

  `VTPD_ASSERT_NOW(a_stall_only_when_full, in_stall, (v_r == '1) && out_stall)
  `VTPD_ASSERT_NOW(a_wzero_outputs_zero, out_valid && (out_status == ST_WZERO),
                   (out_proj_x == '0) && (out_proj_y == '0) && (out_proj_z == '0))
  `VTPD_ASSERT_NOW(a_status_code_valid, out_valid,
                   (out_status == ST_OK) || (out_status == ST_SAT)
                   || (out_status == ST_WZERO))
  `VTPD_ASSERT_NEXT(a_item_advances, v_r[NST-2] && !out_valid, out_valid)

endmodule
